// ===== design/sfcc_pkg.sv =====
// Shared constants, types and helper functions for the sample frame continuity checker.
package sfcc_pkg;

  // Head bytes taken into the batch reference and compared on later frames.
  localparam int HEAD_BYTES = 16;

  // Input item layout (tdata), lowest bit first.
  localparam int COUNT_W   = 16;
  localparam int SEC_W     = 32;
  localparam int US_W      = 20;
  localparam int HEAD_W    = 64;
  localparam int TOTAL_W   = 32;

  localparam int IN_COUNT_LSB = 0;
  localparam int IN_SEC_LSB   = IN_COUNT_LSB + COUNT_W;
  localparam int IN_US_LSB    = IN_SEC_LSB + SEC_W;
  localparam int IN_HLO_LSB   = IN_US_LSB + US_W;
  localparam int IN_HHI_LSB   = IN_HLO_LSB + HEAD_W;
  localparam int IN_USED_W    = IN_HHI_LSB + HEAD_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Result item layout (tdata), lowest bit first.
  localparam int OUT_FBAD_BIT  = 0;
  localparam int OUT_TBAD_BIT  = 1;
  localparam int OUT_TOT_LSB   = 2;
  localparam int OUT_BAD_LSB   = OUT_TOT_LSB + TOTAL_W;
  localparam int OUT_TBT_LSB   = OUT_BAD_LSB + TOTAL_W;
  localparam int OUT_USED_W    = OUT_TBT_LSB + TOTAL_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_CONTENT = 2'd1;

  localparam int RATE_CODE_W = 3;
  localparam logic [RATE_CODE_W-1:0] RATE_4000  = 3'd1;
  localparam logic [RATE_CODE_W-1:0] RATE_5000  = 3'd2;
  localparam logic [RATE_CODE_W-1:0] RATE_8000  = 3'd3;
  localparam logic [RATE_CODE_W-1:0] RATE_10000 = 3'd4;
  localparam logic [RATE_CODE_W-1:0] RATE_12800 = 3'd5;

  localparam int NOM_W = 8;
  localparam logic [31:0] MICROS_PER_SEC = 32'd1000000;

  typedef struct packed {
    logic [SEC_W-1:0]       sec;
    logic [US_W-1:0]        us;
    logic [SEC_W-1:0]       last_sec;
    logic [US_W-1:0]        last_us;
    logic [RATE_CODE_W-1:0] rate_code;
  } time_chk_in_t;

  // Samples per second for a rate code, zero for codes without a rate.
  function automatic logic [COUNT_W-1:0] rate_of(input logic [RATE_CODE_W-1:0] code);
    logic [COUNT_W-1:0] r;
    r = '0;
    case (code)
      RATE_4000:  r = 16'd4000;
      RATE_5000:  r = 16'd5000;
      RATE_8000:  r = 16'd8000;
      RATE_10000: r = 16'd10000;
      RATE_12800: r = 16'd12800;
      default:    r = '0;
    endcase
    return r;
  endfunction

  // Nominal frame spacing in microseconds (1e6 / rate, truncated).
  function automatic logic [NOM_W-1:0] nominal_of(input logic [RATE_CODE_W-1:0] code);
    logic [NOM_W-1:0] n;
    n = '0;
    case (code)
      RATE_4000:  n = 8'd250;
      RATE_5000:  n = 8'd200;
      RATE_8000:  n = 8'd125;
      RATE_10000: n = 8'd100;
      RATE_12800: n = 8'd78;
      default:    n = '0;
    endcase
    return n;
  endfunction

  // Byte mask over one 64-bit head word; word 1 covers bytes 8..15.
  function automatic logic [HEAD_W-1:0] head_mask(input int word);
    logic [HEAD_W-1:0] m;
    m = '0;
    for (int i = 0; i < HEAD_W / 8; i++) begin
      m[8*i +: 8] = ((word * (HEAD_W / 8) + i) < HEAD_BYTES) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== design/sample_frame_continuity_checker.sv =====
// Top level of the sample frame continuity checker.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------------------
//  in_     | slave     | in_tvalid/tready  | tuser: batch_start; tdata: frame summary
//  out_    | master    | out_tvalid/tready | tdata: flags and three wrapping totals
//  cfg_    | slave     | cfg_valid/ready   | cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while out_tready is high; an item passes an input
// register, then the compare-and-update logic feeding the result register.
// Reset (rst_n low, synchronous) clears the valids, the totals, the count and time
// continuity state (not the head reference) and the configuration (rate code 1, content check on).
// A stalled result holds both stages in place; in_tready stays high while the
// input register is empty or the result register can move.
module sample_frame_continuity_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input items.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata from bit 0: count_value[15:0], stamp_seconds[31:0], stamp_micros[19:0],
  // head_low[63:0], head_high[63:0], zero pad
  input  logic [sfcc_pkg::IN_DATA_W-1:0]        in_tdata,
  // tuser: batch_start
  input  logic                                 in_tuser,
  // Result items.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata from bit 0: frame_bad, time_bad, frames_total[31:0], bad_total[31:0],
  // time_bad_total[31:0], zero pad
  output logic [sfcc_pkg::OUT_DATA_W-1:0]       out_tdata,
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers.
  logic [sfcc_pkg::RATE_CODE_W-1:0] rate_code_r;
  logic                             check_content_r;

  // Input register.
  logic                            s1_valid_r;
  logic [sfcc_pkg::IN_USED_W-1:0]  s1_data_r;
  logic                            s1_start_r;

  // Continuity state.
  logic                            awaiting_first_r;
  logic [sfcc_pkg::COUNT_W-1:0]    expected_r;
  logic [sfcc_pkg::SEC_W-1:0]      last_sec_r;
  logic [sfcc_pkg::US_W-1:0]       last_us_r;
  logic [sfcc_pkg::HEAD_W-1:0]     ref_lo_r;
  logic [sfcc_pkg::HEAD_W-1:0]     ref_hi_r;
  logic [sfcc_pkg::TOTAL_W-1:0]    total_r;
  logic [sfcc_pkg::TOTAL_W-1:0]    bad_r;
  logic [sfcc_pkg::TOTAL_W-1:0]    tbad_r;

  // Result register.
  logic                            out_valid_r;
  logic                            out_fbad_r;
  logic                            out_tbad_r;

  // Unpacked fields of the held item.
  logic [sfcc_pkg::COUNT_W-1:0]    count;
  logic [sfcc_pkg::SEC_W-1:0]      sec;
  logic [sfcc_pkg::US_W-1:0]       us;
  logic [sfcc_pkg::HEAD_W-1:0]     hlo;
  logic [sfcc_pkg::HEAD_W-1:0]     hhi;

  logic                            advance;
  logic                            fire;
  logic [sfcc_pkg::COUNT_W-1:0]    exp_eff;
  logic [sfcc_pkg::COUNT_W-1:0]    rate;
  logic                            content_bad;
  logic                            count_bad;
  logic                            fbad_nxt;
  logic                            tbad_nxt;
  logic                            time_ok;
  logic [sfcc_pkg::TOTAL_W-1:0]    total_nxt;
  logic [sfcc_pkg::TOTAL_W-1:0]    bad_nxt;
  logic [sfcc_pkg::TOTAL_W-1:0]    tbad_cnt_nxt;
  sfcc_pkg::time_chk_in_t          tchk;

  // Whole pipeline moves when the result register is empty or being taken.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign fire      = s1_valid_r && advance;
  assign cfg_ready = 1'b1;

  assign count = s1_data_r[sfcc_pkg::IN_COUNT_LSB +: sfcc_pkg::COUNT_W];
  assign sec   = s1_data_r[sfcc_pkg::IN_SEC_LSB   +: sfcc_pkg::SEC_W];
  assign us    = s1_data_r[sfcc_pkg::IN_US_LSB    +: sfcc_pkg::US_W];
  assign hlo   = s1_data_r[sfcc_pkg::IN_HLO_LSB   +: sfcc_pkg::HEAD_W];
  assign hhi   = s1_data_r[sfcc_pkg::IN_HHI_LSB   +: sfcc_pkg::HEAD_W];

  assign tchk.sec       = sec;
  assign tchk.us        = us;
  assign tchk.last_sec  = last_sec_r;
  assign tchk.last_us   = last_us_r;
  assign tchk.rate_code = rate_code_r;

  sfcc_time_chk u_time_chk (
    .chk_in  (tchk),
    .time_ok (time_ok)
  );

  always_comb begin
    rate = sfcc_pkg::rate_of(rate_code_r);
    // First frame seeds the expected count with its own counter.
    exp_eff = awaiting_first_r ? count : expected_r;
    // Compare the masked head against the batch reference on non-start frames.
    content_bad = check_content_r && !s1_start_r &&
                  ((((hlo ^ ref_lo_r) & sfcc_pkg::head_mask(0)) != '0) ||
                   (((hhi ^ ref_hi_r) & sfcc_pkg::head_mask(1)) != '0));
    // Counter mismatch, except a wrap to zero once the count reached the rate.
    count_bad = (exp_eff != count) &&
                !((rate != '0) && (exp_eff == rate) && (count == '0));
    fbad_nxt  = content_bad || count_bad;
    tbad_nxt  = !awaiting_first_r && !time_ok;
    total_nxt    = total_r + 32'd1;
    bad_nxt      = bad_r + {31'd0, fbad_nxt};
    tbad_cnt_nxt = tbad_r + {31'd0, tbad_nxt};
  end

  // Control state, configuration and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_code_r      <= sfcc_pkg::RATE_4000;
      check_content_r  <= 1'b1;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      awaiting_first_r <= 1'b1;
      expected_r       <= '0;
      last_sec_r       <= '0;
      last_us_r        <= '0;
      total_r          <= '0;
      bad_r            <= '0;
      tbad_r           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfcc_pkg::REG_RATE_CODE:     rate_code_r <= cfg_data[sfcc_pkg::RATE_CODE_W-1:0];
          sfcc_pkg::REG_CHECK_CONTENT: check_content_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        awaiting_first_r <= 1'b0;
        // Resync to the received counter, then step by one.
        expected_r       <= count + 16'd1;
        last_sec_r       <= sec;
        last_us_r        <= us;
        total_r          <= total_nxt;
        bad_r            <= bad_nxt;
        tbad_r           <= tbad_cnt_nxt;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_tdata[sfcc_pkg::IN_USED_W-1:0];
      s1_start_r <= in_tuser;
    end
    if (fire) begin
      out_fbad_r <= fbad_nxt;
      out_tbad_r <= tbad_nxt;
      // Capture the reference from a batch's first frame when the content check is on.
      if (check_content_r && s1_start_r) begin
        ref_lo_r <= hlo;
        ref_hi_r <= hhi;
      end
    end
  end

  // Totals in the result are the updated counters, held until the next item.
  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[sfcc_pkg::OUT_FBAD_BIT]                       = out_fbad_r;
    out_tdata[sfcc_pkg::OUT_TBAD_BIT]                       = out_tbad_r;
    out_tdata[sfcc_pkg::OUT_TOT_LSB +: sfcc_pkg::TOTAL_W]   = total_r;
    out_tdata[sfcc_pkg::OUT_BAD_LSB +: sfcc_pkg::TOTAL_W]   = bad_r;
    out_tdata[sfcc_pkg::OUT_TBT_LSB +: sfcc_pkg::TOTAL_W]   = tbad_r;
  end

endmodule

// ===== design/sfcc_time_chk.sv =====
// Timestamp gap check: borrowed microsecond gap within nominal +-1, same second.
module sfcc_time_chk (
  input  sfcc_pkg::time_chk_in_t chk_in,
  output logic                   time_ok
);

  logic                      borrow;
  logic [31:0]               gap;
  logic [sfcc_pkg::SEC_W-1:0] sec_adj;
  logic [31:0]               nom;
  logic                      rate_valid;

  always_comb begin
    borrow     = chk_in.us < chk_in.last_us;
    nom        = {24'd0, sfcc_pkg::nominal_of(chk_in.rate_code)};
    rate_valid = nom != 32'd0;
    if (borrow) begin
      gap     = sfcc_pkg::MICROS_PER_SEC - {12'd0, chk_in.last_us} + {12'd0, chk_in.us};
      sec_adj = chk_in.sec - 32'd1;
    end else begin
      gap     = {12'd0, chk_in.us - chk_in.last_us};
      sec_adj = chk_in.sec;
    end
    time_ok = rate_valid && (gap >= nom - 32'd1) && (gap <= nom + 32'd1) &&
              (sec_adj == chk_in.last_sec);
  end

endmodule

// ===== design/sfcc_chk.sv =====
// Port-level checker for the sample frame continuity checker, with its bind.
module sfcc_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sfcc_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic                         seen_r;
  logic [sfcc_pkg::TOTAL_W-1:0] tot_r;
  logic [sfcc_pkg::TOTAL_W-1:0] bad_r;
  logic [sfcc_pkg::TOTAL_W-1:0] tbt_r;

  logic                         out_acc;
  logic                         fbad;
  logic                         tbad;
  logic [sfcc_pkg::TOTAL_W-1:0] tot;
  logic [sfcc_pkg::TOTAL_W-1:0] bad;
  logic [sfcc_pkg::TOTAL_W-1:0] tbt;

  assign out_acc = out_tvalid && out_tready;
  assign fbad    = out_tdata[sfcc_pkg::OUT_FBAD_BIT];
  assign tbad    = out_tdata[sfcc_pkg::OUT_TBAD_BIT];
  assign tot     = out_tdata[sfcc_pkg::OUT_TOT_LSB +: sfcc_pkg::TOTAL_W];
  assign bad     = out_tdata[sfcc_pkg::OUT_BAD_LSB +: sfcc_pkg::TOTAL_W];
  assign tbt     = out_tdata[sfcc_pkg::OUT_TBT_LSB +: sfcc_pkg::TOTAL_W];

  // Track the last delivered totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      tot_r  <= '0;
      bad_r  <= '0;
      tbt_r  <= '0;
    end else if (out_acc) begin
      seen_r <= 1'b1;
      tot_r  <= tot;
      bad_r  <= bad;
      tbt_r  <= tbt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> tot == tot_r + 32'd1)
    else $error("frames_total did not advance by one");

  a_bad_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (bad == bad_r + {31'd0, fbad}) && (tbt == tbt_r + {31'd0, tbad}))
    else $error("error totals disagree with item flags");

  a_first_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !seen_r |-> !tbad)
    else $error("first frame flagged with a time error");

endmodule

bind sample_frame_continuity_checker sfcc_chk u_sfcc_chk (.*);
